// File: src/ffca_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the first-fit coalescing allocator
// no dependencies

package ffca_pkg;

  localparam int KIND_W  = 1;
  localparam int REQ_W   = 13;
  localparam int REL_W   = 12;
  localparam int OFF_W   = 12;
  localparam int SLACK_W = 8;

  localparam logic [SLACK_W-1:0] SLACK_RESET = 8'd100;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_INIT,
    S_IDLE,
    S_START,
    S_A_RD,
    S_A_CHK,
    S_A_UNL,
    S_A_REST,
    S_F_RD,
    S_F_CHK,
    S_I_START,
    S_I_RD,
    S_I_CHK,
    S_I_POS,
    S_I_RDP,
    S_I_RDN,
    S_I_GETN,
    S_I_MRG,
    S_I_W2,
    S_I_W2N,
    S_FIN_OK,
    S_FIN_FAIL
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_INIT,
    OP_LATCH,
    OP_A_START,
    OP_RD_CUR,
    OP_A_NEXT,
    OP_A_TAKE,
    OP_A_UNLINK,
    OP_A_REST,
    OP_F_START,
    OP_RD_B,
    OP_F_MARK,
    OP_I_HEAD_ONLY,
    OP_I_START,
    OP_RD_W,
    OP_I_NEXT,
    OP_I_STOP,
    OP_I_POS,
    OP_RD_P,
    OP_RD_N,
    OP_GET_N,
    OP_M_LINK,
    OP_M_PREV,
    OP_M_NEXT,
    OP_M_BOTH,
    OP_W2,
    OP_W2N,
    OP_PUSH_OK,
    OP_PUSH_FAIL
  } op_t;

  typedef struct packed {
    logic clr_last;
    logic kind;
    logic head_blk;
    logic fit;
    logic next_blk;
    logic split;
    logic rel_ok;
    logic used;
    logic stop;
    logic same;
    logic pc;
    logic nc;
    logic out_free;
  } dp_status_t;

endpackage

// File: src/ffca_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the allocator: clearing pass, list walks, unlink, split and merge
// depends on ffca_pkg

module ffca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  ffca_pkg::dp_status_t st,
  output ffca_pkg::op_t     op,
  output logic              busy
);
  import ffca_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:    if (st.clr_last) state_next = S_INIT;
      S_INIT:     state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_START;
      S_START: begin
        if (st.kind == KIND_FREE) begin
          state_next = st.rel_ok ? S_F_RD : S_FIN_FAIL;
        end else begin
          state_next = st.head_blk ? S_A_RD : S_FIN_FAIL;
        end
      end
      S_A_RD:     state_next = S_A_CHK;
      S_A_CHK: begin
        if (st.fit) state_next = S_A_UNL;
        else        state_next = st.next_blk ? S_A_RD : S_FIN_FAIL;
      end
      S_A_UNL:    state_next = st.split ? S_A_REST : S_FIN_OK;
      S_A_REST:   state_next = S_I_START;
      S_F_RD:     state_next = S_F_CHK;
      S_F_CHK:    state_next = st.used ? S_I_START : S_FIN_FAIL;
      S_I_START:  state_next = st.head_blk ? S_I_RD : S_FIN_OK;
      S_I_RD:     state_next = S_I_CHK;
      S_I_CHK:    state_next = st.stop ? S_I_POS : S_I_RD;
      S_I_POS:    state_next = st.same ? S_FIN_OK : S_I_RDP;
      S_I_RDP:    state_next = S_I_RDN;
      S_I_RDN:    state_next = S_I_GETN;
      S_I_GETN:   state_next = S_I_MRG;
      S_I_MRG: begin
        priority if (st.pc) state_next = S_FIN_OK;
        else if (st.nc)     state_next = S_I_W2N;
        else                state_next = S_I_W2;
      end
      S_I_W2:     state_next = S_FIN_OK;
      S_I_W2N:    state_next = S_FIN_OK;
      S_FIN_OK:   if (st.out_free) state_next = S_IDLE;
      S_FIN_FAIL: if (st.out_free) state_next = S_IDLE;
      default:    state_next = S_CLEAR;
    endcase
  end

  // command to the datapath
  always_comb begin
    op   = OP_NONE;
    busy = (state != S_IDLE);
    unique case (state)
      S_CLEAR:    op = OP_CLEAR;
      S_INIT:     op = OP_INIT;
      S_IDLE:     op = in_valid ? OP_LATCH : OP_NONE;
      S_START:    op = (st.kind == KIND_FREE) ? OP_F_START : OP_A_START;
      S_A_RD:     op = OP_RD_CUR;
      S_A_CHK:    op = st.fit ? OP_A_TAKE : OP_A_NEXT;
      S_A_UNL:    op = OP_A_UNLINK;
      S_A_REST:   op = OP_A_REST;
      S_F_RD:     op = OP_RD_B;
      S_F_CHK:    op = st.used ? OP_F_MARK : OP_NONE;
      S_I_START:  op = st.head_blk ? OP_I_START : OP_I_HEAD_ONLY;
      S_I_RD:     op = OP_RD_W;
      S_I_CHK:    op = st.stop ? OP_I_STOP : OP_I_NEXT;
      S_I_POS:    op = st.same ? OP_NONE : OP_I_POS;
      S_I_RDP:    op = OP_RD_P;
      S_I_RDN:    op = OP_RD_N;
      S_I_GETN:   op = OP_GET_N;
      S_I_MRG: begin
        priority if (st.pc && st.nc) op = OP_M_BOTH;
        else if (st.pc)              op = OP_M_PREV;
        else if (st.nc)              op = OP_M_NEXT;
        else                         op = OP_M_LINK;
      end
      S_I_W2:     op = OP_W2;
      S_I_W2N:    op = OP_W2N;
      S_FIN_OK:   op = st.out_free ? OP_PUSH_OK : OP_NONE;
      S_FIN_FAIL: op = st.out_free ? OP_PUSH_FAIL : OP_NONE;
      default:    op = OP_NONE;
    endcase
  end

endmodule

// File: src/ffca_dp.sv
`timescale 1ns / 1ps
// datapath: block header memories, free list head, walk registers, result register
// depends on ffca_pkg

module ffca_dp #(
  parameter int ARENA_BYTES        = 4096,
  parameter int BLOCK_HEADER_BYTES = 24,
  parameter int ARENA_HEADER_BYTES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ffca_pkg::op_t                op,
  output ffca_pkg::dp_status_t         st,
  input  logic                         cfg_we,
  input  logic [ffca_pkg::SLACK_W-1:0] cfg_data,
  input  logic [ffca_pkg::KIND_W-1:0]  kind,
  input  logic [ffca_pkg::REQ_W-1:0]   request_size,
  input  logic [ffca_pkg::REL_W-1:0]   release_offset,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         granted,
  output logic [ffca_pkg::OFF_W-1:0]   data_offset
);
  import ffca_pkg::*;

  localparam int LW = $clog2(ARENA_BYTES + 1);
  localparam int IW = $clog2(ARENA_BYTES);
  localparam int SW = ((LW > REQ_W) ? LW : REQ_W) + 2;
  localparam logic [LW-1:0] NIL     = LW'(ARENA_BYTES);
  localparam logic [SW-1:0] BH      = SW'(BLOCK_HEADER_BYTES);
  localparam logic [SW-1:0] ARENA_S = SW'(ARENA_BYTES);
  localparam logic [IW-1:0] FIRST_IX = IW'(ARENA_HEADER_BYTES);
  localparam logic [LW-1:0] FIRST_A  = LW'(ARENA_HEADER_BYTES);
  localparam logic [LW-1:0] FIRST_SZ =
    LW'(ARENA_BYTES - ARENA_HEADER_BYTES - BLOCK_HEADER_BYTES);
  localparam logic [IW-1:0] LAST_IX = IW'(ARENA_BYTES - 1);

  // header store, one field per memory
  logic [LW-1:0] size_mem [ARENA_BYTES];
  logic [LW-1:0] prev_mem [ARENA_BYTES];
  logic [LW-1:0] next_mem [ARENA_BYTES];
  logic          used_mem [ARENA_BYTES];

  logic [LW-1:0] rsize, rprev, rnext;
  logic          rused;

  logic          s_we, p_we, n_we, u_we;
  logic [IW-1:0] s_wa, p_wa, n_wa, u_wa, raddr;
  logic [LW-1:0] s_wd, p_wd, n_wd;
  logic          u_wd;

  logic [IW-1:0]      cnt;
  logic [SLACK_W-1:0] slack;
  logic [LW-1:0]      head;
  logic               kind_r;
  logic [REQ_W-1:0]   req;
  logic [REL_W-1:0]   rel;
  logic [LW-1:0]      cur, csize, cp, cn;
  logic [LW-1:0]      w, b, sb, p, n, sp, sn, nn;

  logic [SW-1:0] rest_s, rest_size_s, rel_b_s, split_need;
  logic [SW-1:0] pend_s, bend_s, merge_p_s, merge_b_s, merge_both_s, off_s;

  function automatic logic is_blk(input logic [LW-1:0] x);
    return SW'(x) < ARENA_S;
  endfunction

  always_comb begin
    rest_s       = SW'(cur) + BH + SW'(req);
    rest_size_s  = SW'(csize) - SW'(req) - BH;
    split_need   = SW'(req) + BH + SW'(slack);
    rel_b_s      = SW'(rel) - BH;
    pend_s       = SW'(p) + BH + SW'(sp);
    bend_s       = SW'(b) + BH + SW'(sb);
    merge_p_s    = SW'(sp) + BH + SW'(sb);
    merge_b_s    = SW'(sb) + BH + SW'(sn);
    merge_both_s = SW'(sp) + BH + BH + SW'(sb) + SW'(sn);
    off_s        = SW'(cur) + BH;
  end

  always_comb begin
    st.clr_last = (cnt == LAST_IX);
    st.kind     = kind_r;
    st.head_blk = is_blk(head);
    st.fit      = (SW'(rsize) >= SW'(req));
    st.next_blk = is_blk(rnext);
    st.split    = (SW'(csize) >= split_need) && (rest_s < ARENA_S);
    st.rel_ok   = (SW'(rel) >= BH) && (rel_b_s < ARENA_S);
    st.used     = rused;
    st.stop     = (w > b) || !is_blk(rnext);
    st.same     = (w == b);
    st.pc       = is_blk(p) && (pend_s == SW'(b));
    st.nc       = is_blk(n) && (bend_s == SW'(n));
    st.out_free = !out_valid || !out_stall;
  end

  // memory write ports and read address
  always_comb begin
    s_we = 1'b0; s_wa = '0; s_wd = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0;
    n_we = 1'b0; n_wa = '0; n_wd = '0;
    u_we = 1'b0; u_wa = '0; u_wd = 1'b0;
    raddr = cur[IW-1:0];
    unique case (op)
      OP_CLEAR: begin
        s_we = 1'b1; s_wa = cnt;
        p_we = 1'b1; p_wa = cnt;
        n_we = 1'b1; n_wa = cnt;
        u_we = 1'b1; u_wa = cnt;
      end
      OP_INIT: begin
        s_we = 1'b1; s_wa = FIRST_IX; s_wd = FIRST_SZ;
        p_we = 1'b1; p_wa = FIRST_IX; p_wd = NIL;
        n_we = 1'b1; n_wa = FIRST_IX; n_wd = NIL;
      end
      OP_RD_CUR: raddr = cur[IW-1:0];
      OP_RD_B:   raddr = b[IW-1:0];
      OP_RD_W:   raddr = w[IW-1:0];
      OP_RD_P:   raddr = p[IW-1:0];
      OP_RD_N:   raddr = n[IW-1:0];
      OP_A_UNLINK: begin
        n_we = is_blk(cp); n_wa = cp[IW-1:0]; n_wd = cn;
        p_we = is_blk(cn); p_wa = cn[IW-1:0]; p_wd = cp;
        u_we = 1'b1; u_wa = cur[IW-1:0]; u_wd = 1'b1;
        // taken block shrinks to the request when split
        s_we = st.split; s_wa = cur[IW-1:0]; s_wd = LW'(req);
      end
      OP_A_REST: begin
        s_we = 1'b1; s_wa = rest_s[IW-1:0]; s_wd = rest_size_s[LW-1:0];
        u_we = 1'b1; u_wa = rest_s[IW-1:0]; u_wd = 1'b0;
      end
      OP_F_MARK: begin
        u_we = 1'b1; u_wa = b[IW-1:0]; u_wd = 1'b0;
      end
      OP_I_HEAD_ONLY: begin
        p_we = 1'b1; p_wa = b[IW-1:0]; p_wd = NIL;
        n_we = 1'b1; n_wa = b[IW-1:0]; n_wd = NIL;
      end
      OP_M_LINK: begin
        p_we = 1'b1; p_wa = b[IW-1:0]; p_wd = p;
        n_we = 1'b1; n_wa = b[IW-1:0]; n_wd = n;
      end
      OP_M_PREV: begin
        s_we = 1'b1; s_wa = p[IW-1:0]; s_wd = merge_p_s[LW-1:0];
      end
      OP_M_NEXT: begin
        p_we = 1'b1; p_wa = b[IW-1:0]; p_wd = p;
        n_we = 1'b1; n_wa = b[IW-1:0]; n_wd = nn;
        s_we = 1'b1; s_wa = b[IW-1:0]; s_wd = merge_b_s[LW-1:0];
      end
      OP_M_BOTH: begin
        s_we = 1'b1; s_wa = p[IW-1:0]; s_wd = merge_both_s[LW-1:0];
        n_we = 1'b1; n_wa = p[IW-1:0]; n_wd = nn;
        p_we = is_blk(nn); p_wa = nn[IW-1:0]; p_wd = p;
      end
      OP_W2: begin
        n_we = is_blk(p); n_wa = p[IW-1:0]; n_wd = b;
        p_we = is_blk(n); p_wa = n[IW-1:0]; p_wd = b;
      end
      OP_W2N: begin
        n_we = is_blk(p); n_wa = p[IW-1:0]; n_wd = b;
        p_we = is_blk(nn); p_wa = nn[IW-1:0]; p_wd = b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) size_mem[s_wa] <= s_wd;
    if (p_we) prev_mem[p_wa] <= p_wd;
    if (n_we) next_mem[n_wa] <= n_wd;
    if (u_we) used_mem[u_wa] <= u_wd;
    rsize <= size_mem[raddr];
    rprev <= prev_mem[raddr];
    rnext <= next_mem[raddr];
    rused <= used_mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      slack     <= SLACK_RESET;
      out_valid <= 1'b0;
    end else begin
      if (op == OP_CLEAR) cnt <= cnt + 1'b1;
      if (cfg_we) slack <= cfg_data;
      if (op == OP_PUSH_OK || op == OP_PUSH_FAIL) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_INIT:  head <= FIRST_A;
      OP_LATCH: begin
        kind_r <= kind;
        req    <= request_size;
        rel    <= release_offset;
      end
      OP_A_START: cur <= head;
      OP_A_NEXT:  cur <= rnext;
      OP_A_TAKE: begin
        csize <= rsize;
        cp    <= rprev;
        cn    <= rnext;
      end
      OP_A_UNLINK: if (!is_blk(cp)) head <= cn;
      OP_A_REST: begin
        b  <= rest_s[LW-1:0];
        sb <= rest_size_s[LW-1:0];
      end
      OP_F_START:     b <= rel_b_s[LW-1:0];
      OP_F_MARK:      sb <= rsize;
      OP_I_HEAD_ONLY: head <= b;
      OP_I_START:     w <= head;
      OP_I_NEXT:      w <= rnext;
      OP_I_STOP: begin
        cp <= rprev;
        cn <= rnext;
      end
      OP_I_POS: begin
        if (w < b) begin
          p <= w;
          n <= cn;
        end else begin
          p <= cp;
          n <= w;
        end
      end
      OP_RD_N: sp <= rsize;
      OP_GET_N: begin
        sn <= rsize;
        nn <= rnext;
      end
      OP_M_LINK, OP_M_NEXT: ;
      OP_W2, OP_W2N: if (!is_blk(p)) head <= b;
      OP_PUSH_OK: begin
        granted     <= 1'b1;
        data_offset <= (kind_r == KIND_FREE) ? '0 : off_s[OFF_W-1:0];
      end
      OP_PUSH_FAIL: begin
        granted     <= 1'b0;
        data_offset <= '0;
      end
      default: ;
    endcase
  end

endmodule

// File: src/first_fit_coalescing_allocator_top.sv
`timescale 1ns / 1ps
// top level of the first-fit coalescing allocator
// depends on ffca_pkg, ffca_ctrl and ffca_dp
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid / cfg_ready  cfg_data (split slack)
//  in        in         in_valid / in_stall    kind, request_size, release_offset
//  out       out        out_valid / out_stall  granted, data_offset
//
// an allocate walks the free list from its head and takes the first block that fits;
// with a split, the rest goes back into the list by an insert walk. a free marks its
// block unused and inserts it by a walk from the head, merging with adjacent free
// neighbours. an allocate is refused when no block fits, a free when the offset is
// out of range or the block is not in use. the header memories share one read address.
// after reset a clearing pass over all ARENA_BYTES headers runs with in_stall high.
// a finished item waits while the previous result is held by out_stall; once its
// result is registered, the next item is let in while that result waits.

module first_fit_coalescing_allocator_top #(
  parameter int ARENA_BYTES        = 4096,
  parameter int BLOCK_HEADER_BYTES = 24,
  parameter int ARENA_HEADER_BYTES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ffca_pkg::SLACK_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ffca_pkg::KIND_W-1:0]  kind,
  input  logic [ffca_pkg::REQ_W-1:0]   request_size,
  input  logic [ffca_pkg::REL_W-1:0]   release_offset,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         granted,
  output logic [ffca_pkg::OFF_W-1:0]   data_offset
);
  import ffca_pkg::*;

  op_t        op;
  dp_status_t st;
  logic       busy;

  // the slack register only takes a write while no item is in work
  assign cfg_ready = !busy;
  // an item is only taken by the idle controller
  assign in_stall  = busy;

  ffca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .op       (op),
    .busy     (busy)
  );

  ffca_dp #(
    .ARENA_BYTES        (ARENA_BYTES),
    .BLOCK_HEADER_BYTES (BLOCK_HEADER_BYTES),
    .ARENA_HEADER_BYTES (ARENA_HEADER_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .st             (st),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .request_size   (request_size),
    .release_offset (release_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .granted        (granted),
    .data_offset    (data_offset)
  );

`ifndef SYNTH
  // after taking an item the block is busy with it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after taking an item");

  // a refused request carries no offset
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> data_offset == '0)
    else $error("offset given with a refused request");

  // a new result only appears at the end of work on an item
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an item in work");
`endif

endmodule
